FILE: sv/rrr_pkg.sv
// Shared types, widths and helpers for the ray reflect/refract core.
package rrr_pkg;

    localparam int COMP_W   = 16;   // component width, signed Q3.12
    localparam int RATIO_W  = 16;   // index ratio width, unsigned Q4.12
    localparam int FRAC     = 12;
    localparam int DT_W     = 22;   // d.n after the Q.12 scale
    localparam int A_W      = 26;   // d - n*dt per component
    localparam int OMD_W    = 29;   // 1 - dt*dt
    localparam int R2_W     = 20;   // r*r after the Q.12 scale
    localparam int DISC_W   = 39;   // discriminant
    localparam int SQ_N     = 24;   // square root result bits, one per stage
    localparam int RAD_W    = 2 * SQ_N;
    localparam int REM_W    = SQ_N + 3;
    localparam int PIPE_LAT = 6 + SQ_N + 2;

    localparam logic OP_REFLECT = 1'b0;
    localparam logic OP_REFRACT = 1'b1;

    typedef logic signed [COMP_W-1:0] t_comp;
    typedef logic signed [A_W-1:0]    t_avec;

    typedef struct packed {
        logic                op;
        t_comp               dir_x;
        t_comp               dir_y;
        t_comp               dir_z;
        t_comp               normal_x;
        t_comp               normal_y;
        t_comp               normal_z;
        logic [RATIO_W-1:0]  ratio;
    } t_in_word;

    typedef struct packed {
        t_comp out_x;
        t_comp out_y;
        t_comp out_z;
        logic  ok;
    } t_out_word;

    // Fields that ride alongside the square root stages.
    typedef struct packed {
        logic               op;
        logic               pos;
        logic [RATIO_W-1:0] r;
        t_comp [2:0]        n;
        t_avec [2:0]        a;
        t_comp [2:0]        refl;
    } t_side;

    function automatic t_comp sat_comp(input logic signed [31:0] v);
        t_comp hi;
        t_comp lo;
        hi = {1'b0, {(COMP_W-1){1'b1}}};
        lo = {1'b1, {(COMP_W-1){1'b0}}};
        if (v > 32'(hi)) begin
            return hi;
        end else if (v < 32'(lo)) begin
            return lo;
        end
        return v[COMP_W-1:0];
    endfunction

endpackage

FILE: sv/ray_reflect_refract_core.sv
// Top level: pipelined ray reflection and Snell refraction.
//
// Usage:
//   Drive a word on i_word and raise start; the word is taken at every rising
//   edge with start high. busy is always low: the pipeline takes one word per
//   cycle with no gaps, back to back.
//   Each word yields exactly one result word on o_res, marked by o_done. o_done
//   is the word's start bit carried down the r_vld valid chain beside the data,
//   and the result is taken at the edge that ends the cycle in which o_done is high.
//   Stages: dot products, dt, n*dt and dt*dt, reflect result and 1-dt^2,
//   r^2*(1-dt^2), discriminant, 24 square root stages (one root bit each),
//   final products, output saturation. The 24-bit square root sets the depth.
//   Reflect (op 0): out = d - 2(d.n)n, ok = 1. Refract (op 1): out =
//   r(d - n dt) - n sqrt(disc) with ok = 1 if disc > 0, else zeros and ok = 0.
//   All outputs saturate to signed Q3.12.
//   Reset (synchronous, active low) clears the valid bits only; words in
//   flight are dropped. The receiver cannot stall: it must take every o_done.
module ray_reflect_refract_core
    import rrr_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      start,
    output logic      busy,
    input  t_in_word  i_word,
    output logic      o_done,
    output t_out_word o_res
);

    // Valid bits travel down with the data.
    logic [PIPE_LAT-1:0] r_vld;
    logic [PIPE_LAT-1:0] n_vld;

    assign busy  = 1'b0;
    assign n_vld = {r_vld[PIPE_LAT-2:0], start};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign o_done = r_vld[PIPE_LAT-1];

    // Stage 1: per-component d*n products and r*r.
    t_comp s0_d [3];
    t_comp s0_n [3];
    assign s0_d[0] = i_word.dir_x;
    assign s0_d[1] = i_word.dir_y;
    assign s0_d[2] = i_word.dir_z;
    assign s0_n[0] = i_word.normal_x;
    assign s0_n[1] = i_word.normal_y;
    assign s0_n[2] = i_word.normal_z;

    logic signed [31:0]   r1_p [3];
    t_comp                r1_d [3];
    t_comp                r1_n [3];
    logic [R2_W-1:0]      r1_r2;
    logic [RATIO_W-1:0]   r1_r;
    logic                 r1_op;
    logic [2*RATIO_W-1:0] s1_rr;

    assign s1_rr = i_word.ratio * i_word.ratio;

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r1_p[i] <= s0_d[i] * s0_n[i];
            r1_d[i] <= s0_d[i];
            r1_n[i] <= s0_n[i];
        end
        r1_r2 <= s1_rr[FRAC +: R2_W];
        r1_r  <= i_word.ratio;
        r1_op <= i_word.op;
    end

    // Stage 2: dt = floor(d.n / 4096).
    logic signed [33:0]     s2_sum;
    logic signed [DT_W-1:0] r2_dt;
    t_comp                  r2_d [3];
    t_comp                  r2_n [3];
    logic [R2_W-1:0]        r2_r2;
    logic [RATIO_W-1:0]     r2_r;
    logic                   r2_op;

    assign s2_sum = 34'(r1_p[0]) + 34'(r1_p[1]) + 34'(r1_p[2]);

    always_ff @(posedge i_clk) begin
        r2_dt <= s2_sum[FRAC +: DT_W];
        r2_d  <= r1_d;
        r2_n  <= r1_n;
        r2_r2 <= r1_r2;
        r2_r  <= r1_r;
        r2_op <= r1_op;
    end

    // Stage 3: n*dt per component and dt*dt.
    logic signed [COMP_W+DT_W-1:0] r3_nd [3];
    logic signed [2*DT_W-1:0]      r3_dd;
    t_comp                         r3_d [3];
    t_comp                         r3_n [3];
    logic [R2_W-1:0]               r3_r2;
    logic [RATIO_W-1:0]            r3_r;
    logic                          r3_op;

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r3_nd[i] <= r2_n[i] * r2_dt;
        end
        r3_dd <= r2_dt * r2_dt;
        r3_d  <= r2_d;
        r3_n  <= r2_n;
        r3_r2 <= r2_r2;
        r3_r  <= r2_r;
        r3_op <= r2_op;
    end

    // Stage 4: reflect result, d - n*dt, and 1 - dt^2.
    t_avec                   s4_m [3];
    logic signed [31:0]      s4_refl [3];
    logic signed [31:0]      s4_dt2;
    t_avec                   r4_a [3];
    t_comp                   r4_refl [3];
    logic signed [OMD_W-1:0] r4_omd;
    t_comp                   r4_n [3];
    logic [R2_W-1:0]         r4_r2;
    logic [RATIO_W-1:0]      r4_r;
    logic                    r4_op;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            s4_m[i]    = r3_nd[i][FRAC +: A_W];
            s4_refl[i] = 32'(r3_d[i]) - 32'(s4_m[i]) - 32'(s4_m[i]);
        end
        s4_dt2 = r3_dd[FRAC +: 32];
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r4_a[i]    <= A_W'(r3_d[i]) - s4_m[i];
            r4_refl[i] <= sat_comp(s4_refl[i]);
        end
        r4_omd <= OMD_W'((32'sd1 <<< FRAC) - s4_dt2);
        r4_n   <= r3_n;
        r4_r2  <= r3_r2;
        r4_r   <= r3_r;
        r4_op  <= r3_op;
    end

    // Stage 5: r^2 * (1 - dt^2).
    logic signed [R2_W:0]         s5_r2;
    logic signed [R2_W+OMD_W:0]   r5_p;
    t_side                        r5_side;

    assign s5_r2 = {1'b0, r4_r2};

    always_ff @(posedge i_clk) begin
        r5_p         <= s5_r2 * r4_omd;
        r5_side.op   <= r4_op;
        r5_side.pos  <= 1'b0;
        r5_side.r    <= r4_r;
        for (int i = 0; i < 3; i++) begin
            r5_side.n[i]    <= r4_n[i];
            r5_side.a[i]    <= r4_a[i];
            r5_side.refl[i] <= r4_refl[i];
        end
    end

    // Stage 6: discriminant and square root radicand.
    logic signed [DISC_W-1:0] s6_disc;
    logic                     s6_pos;
    t_side                    s6_side;
    logic [RAD_W-1:0]         r6_rad;
    t_side                    r6_side;

    assign s6_disc = (DISC_W'(1) <<< FRAC) - DISC_W'(r5_p >>> FRAC);
    assign s6_pos  = !s6_disc[DISC_W-1] && (s6_disc != '0);

    always_comb begin
        s6_side     = r5_side;
        s6_side.pos = s6_pos;
    end

    always_ff @(posedge i_clk) begin
        r6_rad  <= s6_pos ? {s6_disc[RAD_W-FRAC-1:0], {FRAC{1'b0}}} : '0;
        r6_side <= s6_side;
    end

    // Square root: one root bit per stage, restoring digit recurrence.
    logic [REM_W-1:0] r_sq_rem  [SQ_N];
    logic [SQ_N-1:0]  r_sq_root [SQ_N];
    logic [RAD_W-1:0] r_sq_rad  [SQ_N];
    t_side            r_sq_side [SQ_N];

    for (genvar k = 0; k < SQ_N; k++) begin : g_sq
        logic [REM_W-1:0] s_rem_in;
        logic [SQ_N-1:0]  s_root_in;
        logic [RAD_W-1:0] s_rad_in;
        t_side            s_side_in;
        logic [REM_W-1:0] s_rem_sh;
        logic [REM_W-1:0] s_trial;

        if (k == 0) begin : g_first
            assign s_rem_in  = '0;
            assign s_root_in = '0;
            assign s_rad_in  = r6_rad;
            assign s_side_in = r6_side;
        end else begin : g_next
            assign s_rem_in  = r_sq_rem[k-1];
            assign s_root_in = r_sq_root[k-1];
            assign s_rad_in  = r_sq_rad[k-1];
            assign s_side_in = r_sq_side[k-1];
        end

        assign s_rem_sh = {s_rem_in[REM_W-3:0], s_rad_in[RAD_W-1 -: 2]};
        assign s_trial  = {1'b0, s_root_in, 2'b01};

        always_ff @(posedge i_clk) begin
            if (s_rem_sh >= s_trial) begin
                r_sq_rem[k]  <= s_rem_sh - s_trial;
                r_sq_root[k] <= {s_root_in[SQ_N-2:0], 1'b1};
            end else begin
                r_sq_rem[k]  <= s_rem_sh;
                r_sq_root[k] <= {s_root_in[SQ_N-2:0], 1'b0};
            end
            r_sq_rad[k]  <= {s_rad_in[RAD_W-3:0], 2'b00};
            r_sq_side[k] <= s_side_in;
        end
    end

    // Stage 7: r*a and n*sqrt(disc).
    t_side                          s7_side;
    logic signed [SQ_N:0]           s7_sq;
    logic signed [RATIO_W:0]        s7_r;
    logic signed [RATIO_W+A_W:0]    r7_ra [3];
    logic signed [COMP_W+SQ_N:0]    r7_ns [3];
    t_comp                          r7_refl [3];
    logic                           r7_op;
    logic                           r7_pos;

    assign s7_side = r_sq_side[SQ_N-1];
    assign s7_sq   = {1'b0, r_sq_root[SQ_N-1]};
    assign s7_r    = {1'b0, s7_side.r};

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r7_ra[i]   <= s7_r * $signed(s7_side.a[i]);
            r7_ns[i]   <= $signed(s7_side.n[i]) * s7_sq;
            r7_refl[i] <= $signed(s7_side.refl[i]);
        end
        r7_op  <= s7_side.op;
        r7_pos <= s7_side.pos;
    end

    // Stage 8: combine, saturate and pick the result by op.
    logic signed [31:0] s8_res [3];
    t_comp              s8_out [3];
    logic               s8_ok;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            s8_res[i] = 32'(r7_ra[i] >>> FRAC) - 32'(r7_ns[i] >>> FRAC);
        end
        case (r7_op)
            OP_REFLECT: begin
                s8_ok = 1'b1;
                for (int i = 0; i < 3; i++) begin
                    s8_out[i] = r7_refl[i];
                end
            end
            OP_REFRACT: begin
                s8_ok = r7_pos;
                for (int i = 0; i < 3; i++) begin
                    s8_out[i] = r7_pos ? sat_comp(s8_res[i]) : '0;
                end
            end
            default: begin
                s8_ok = 1'b0;
                for (int i = 0; i < 3; i++) begin
                    s8_out[i] = '0;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        o_res.out_x <= s8_out[0];
        o_res.out_y <= s8_out[1];
        o_res.out_z <= s8_out[2];
        o_res.ok    <= s8_ok;
    end

`ifndef SYNTHESIS
    a_done_follows_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(start, PIPE_LAT))
        else $error("result strobe without a matching start");

    a_tir_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_res.ok) |->
            (o_res.out_x == '0 && o_res.out_y == '0 && o_res.out_z == '0))
        else $error("total internal reflection with nonzero direction");

    a_reflect_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && $past(start && i_word.op == OP_REFLECT, PIPE_LAT)) |-> o_res.ok)
        else $error("reflect word returned without ok");
`endif

endmodule

FILE: sim/testbench.sv
// Testbench for the ray reflect/refract core: table-driven directed words, then random bursts.
module testbench;
    import rrr_pkg::*;

    logic      i_clk;
    logic      i_rst_n;
    logic      start;
    logic      busy;
    t_in_word  i_word;
    logic      o_done;
    t_out_word o_res;

    ray_reflect_refract_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_word  (i_word),
        .o_done  (o_done),
        .o_res   (o_res)
    );

    // One directed row: input word, and optionally a typed-in expected result.
    typedef struct {
        t_in_word  w;
        bit        fixed;
        t_out_word res;
    } t_row;

    t_out_word ray_q[$];
    int        n_err;
    int        n_words;
    int        n_results;
    int        n_refract;
    int        n_tir;
    bit        stim_done;

    // Floor shift right by 12 of a signed value.
    function automatic longint fl12(input longint v);
        return v >>> FRAC;
    endfunction

    function automatic longint sat_w(input longint v, input int bits);
        longint hi;
        longint lo;
        hi = (longint'(1) << (bits - 1)) - 1;
        lo = -hi - 1;
        if (v > hi) begin
            return hi;
        end
        if (v < lo) begin
            return lo;
        end
        return v;
    endfunction

    function automatic longint root_floor(input longint v);
        longint lo_r;
        longint hi_r;
        longint mid;
        lo_r = 0;
        hi_r = 32'hFFFF_FFFF;
        while (lo_r < hi_r) begin
            mid = (lo_r + hi_r + 1) / 2;
            if (mid * mid <= v) begin
                lo_r = mid;
            end else begin
                hi_r = mid - 1;
            end
        end
        return lo_r;
    endfunction

    // Work out the bent or mirrored ray for one word.
    function automatic t_out_word bend_ray(input t_in_word w);
        longint d[3];
        longint n[3];
        longint rv[3];
        longint r;
        longint dt;
        longint omd;
        longint r2;
        longint disc;
        longint sq;
        longint a;
        t_out_word o;
        d[0] = w.dir_x;    d[1] = w.dir_y;    d[2] = w.dir_z;
        n[0] = w.normal_x; n[1] = w.normal_y; n[2] = w.normal_z;
        r = w.ratio;
        dt = sat_w(fl12(d[0] * n[0] + d[1] * n[1] + d[2] * n[2]), 32);
        o.ok = 1'b1;
        if (w.op == OP_REFLECT) begin
            for (int i = 0; i < 3; i++) begin
                rv[i] = d[i] - 2 * fl12(n[i] * dt);
            end
        end else begin
            omd = sat_w(4096 - fl12(dt * dt), 32);
            r2 = (r * r) >> FRAC;
            disc = 4096 - fl12(r2 * omd);
            if (disc > 0) begin
                sq = root_floor(disc << FRAC);
                for (int i = 0; i < 3; i++) begin
                    a = sat_w(d[i] - fl12(n[i] * dt), 32);
                    rv[i] = fl12(r * a) - fl12(n[i] * sq);
                end
            end else begin
                o.ok = 1'b0;
                for (int i = 0; i < 3; i++) begin
                    rv[i] = 0;
                end
            end
        end
        o.out_x = t_comp'(sat_w(rv[0], COMP_W));
        o.out_y = t_comp'(sat_w(rv[1], COMP_W));
        o.out_z = t_comp'(sat_w(rv[2], COMP_W));
        return o;
    endfunction

    function automatic t_in_word mk(input logic op, input int dx, input int dy, input int dz,
                                    input int nx, input int ny, input int nz, input int r);
        t_in_word w;
        w.op = op;
        w.dir_x = t_comp'(dx);    w.dir_y = t_comp'(dy);    w.dir_z = t_comp'(dz);
        w.normal_x = t_comp'(nx); w.normal_y = t_comp'(ny); w.normal_z = t_comp'(nz);
        w.ratio = 16'(r);
        return w;
    endfunction

    function automatic t_out_word rs(input int x, input int y, input int z, input logic ok);
        t_out_word o;
        o.out_x = t_comp'(x);
        o.out_y = t_comp'(y);
        o.out_z = t_comp'(z);
        o.ok = ok;
        return o;
    endfunction

    // Random component: unit-ish vectors mostly, full range sometimes.
    function automatic int rnd_comp(input bit wide);
        if (wide) begin
            return int'($urandom_range(65535)) - 32768;
        end
        return int'($urandom_range(8192)) - 4096;
    endfunction

    function automatic t_in_word rnd_word();
        t_in_word w;
        bit wide;
        wide = ($urandom_range(9) == 0);
        w = mk(1'($urandom_range(1)), rnd_comp(wide), rnd_comp(wide), rnd_comp(wide),
               rnd_comp(wide), rnd_comp(wide), rnd_comp(wide), 0);
        case ($urandom_range(3))
            0: w.ratio = 16'($urandom_range(65535));
            default: w.ratio = 16'($urandom_range(2048, 6144));
        endcase
        return w;
    endfunction

    // Clock.
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Hard stop on a hang.
    initial begin
        #2000000;
        $display("FAIL");
        $finish;
    end

    // Result side: the core cannot be stalled, so take every done.
    always @(posedge i_clk) begin
        t_out_word exp_w;
        if (i_rst_n && o_done) begin
            n_results++;
            if (ray_q.size() == 0) begin
                $error("result with nothing expected: %p", o_res);
                n_err++;
            end else begin
                exp_w = ray_q.pop_front();
                if (o_res.out_x !== exp_w.out_x) begin
                    $error("out_x expected %0d got %0d", exp_w.out_x, o_res.out_x);
                    n_err++;
                end
                if (o_res.out_y !== exp_w.out_y) begin
                    $error("out_y expected %0d got %0d", exp_w.out_y, o_res.out_y);
                    n_err++;
                end
                if (o_res.out_z !== exp_w.out_z) begin
                    $error("out_z expected %0d got %0d", exp_w.out_z, o_res.out_z);
                    n_err++;
                end
                if (o_res.ok !== exp_w.ok) begin
                    $error("ok expected %0d got %0d", exp_w.ok, o_res.ok);
                    n_err++;
                end
            end
        end
    end

    // Hold one word on the inputs until the core takes it; start stays high across
    // back-to-back words, and is lowered only when a gap follows.
    task automatic send_word(input t_in_word w, input bit fixed, input t_out_word res,
                             input bit last_in_burst);
        @(negedge i_clk);
        i_word <= w;
        start  <= 1'b1;
        do begin
            @(posedge i_clk);
        end while (busy);
        ray_q.push_back(fixed ? res : bend_ray(w));
        n_words++;
        if (w.op == OP_REFRACT) begin
            n_refract++;
            if (!bend_ray(w).ok) begin
                n_tir++;
            end
        end
        if (last_in_burst) begin
            @(negedge i_clk);
            start <= 1'b0;
        end
    endtask

    task automatic idle_cycles(input int n);
        repeat (n) @(negedge i_clk);
    endtask

    initial begin
        t_row rows[$];
        t_out_word none;
        int burst;
        bit drained;
        n_err = 0; n_words = 0; n_results = 0; n_refract = 0; n_tir = 0;
        stim_done = 1'b0;
        drained = 1'b0;
        none = rs(0, 0, 0, 1'b0);
        i_rst_n = 1'b0;
        start = 1'b0;
        i_word = '0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed rows: obvious results typed in, the rest predicted.
        rows.push_back('{mk(OP_REFLECT, 0, 0, 0, 0, 0, 0, 0), 1, rs(0, 0, 0, 1)});
        rows.push_back('{mk(OP_REFLECT, 0, 0, -4096, 0, 0, 4096, 0), 1, rs(0, 0, 4096, 1)});
        rows.push_back('{mk(OP_REFLECT, 4096, 0, 0, 0, 4096, 0, 65535), 1,
                         rs(4096, 0, 0, 1)});
        // Refract with ratio zero: disc is one, out = -n.
        rows.push_back('{mk(OP_REFRACT, 0, 0, -4096, 0, 0, 4096, 0), 1, rs(0, 0, -4096, 1)});
        // Grazing ray, large ratio: total internal reflection.
        rows.push_back('{mk(OP_REFRACT, 4096, 0, 0, 0, 4096, 0, 8192), 1, rs(0, 0, 0, 0)});
        rows.push_back('{mk(OP_REFRACT, 4096, 0, 0, 0, 4096, 0, 65535), 1, rs(0, 0, 0, 0)});
        rows.push_back('{mk(OP_REFRACT, 4096, 0, 0, 0, 4096, 0, 4096), 0, none});
        rows.push_back('{mk(OP_REFRACT, 2896, -2896, 0, 0, 4096, 0, 3072), 0, none});
        rows.push_back('{mk(OP_REFRACT, 2896, -2896, 0, 0, 4096, 0, 5461), 0, none});
        // Extremes: saturation in both directions.
        rows.push_back('{mk(OP_REFLECT, 32767, 32767, 32767, 32767, 32767, 32767, 0), 0, none});
        rows.push_back('{mk(OP_REFLECT, -32768, -32768, -32768, -32768, -32768, -32768, 0),
                         0, none});
        rows.push_back('{mk(OP_REFLECT, 32767, -32768, 32767, -32768, 32767, -32768, 0),
                         0, none});
        rows.push_back('{mk(OP_REFRACT, 32767, 32767, 32767, 32767, 32767, 32767, 65535),
                         0, none});
        rows.push_back('{mk(OP_REFRACT, -32768, -32768, -32768, -32768, -32768, -32768, 65535),
                         0, none});
        rows.push_back('{mk(OP_REFRACT, -32768, 32767, -32768, 32767, -32768, 32767, 1),
                         0, none});
        rows.push_back('{mk(OP_REFRACT, 32767, 32767, 32767, 0, 0, 0, 65535), 0, none});
        rows.push_back('{mk(OP_REFRACT, -1, -1, -1, -1, -1, -1, 65535), 0, none});
        rows.push_back('{mk(OP_REFLECT, -1, 1, -1, 1, -1, 1, 65535), 0, none});
        rows.push_back('{mk(OP_REFRACT, 1000, -2000, -3000, 1234, 2345, 3456, 4915), 0, none});

        foreach (rows[i]) begin
            send_word(rows[i].w, rows[i].fixed, rows[i].res, (i % 4) == 3);
        end
        @(negedge i_clk);
        start <= 1'b0;

        // Random bursts with random gaps; some bursts run flat out.
        for (int k = 0; k < 1200; k += burst) begin
            burst = $urandom_range(1, 40);
            for (int j = 0; j < burst; j++) begin
                send_word(rnd_word(), 1'b0, none, j == burst - 1);
            end
            if ($urandom_range(2) != 0) begin
                idle_cycles($urandom_range(1, 12));
            end
            // Drain the pipe once midway.
            if (!drained && k >= 500) begin
                wait (ray_q.size() == 0);
                drained = 1'b1;
            end
        end

        wait (ray_q.size() == 0);
        idle_cycles(PIPE_LAT + 8);
        $display("Sent %0d words (%0d refract, %0d total internal reflection), checked %0d",
                 n_words, n_refract, n_tir, n_results);
        if (n_err == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
